### src/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg
// Types and constants shared by the multi-compressor selector.
// ----------------------------------------------------------------------------
`default_nettype none

package mcs_pkg;

    localparam int SLOTS = 4;
    localparam logic [12:0] SIZE_MAX_BITS = 13'd8191;
    localparam logic [5:0] MOD_STEPS = 6'd32;
    localparam logic [5:0] FACTOR_STEPS = 6'd9;

    localparam logic [2:0] CFG_BLOCK_BYTES     = 3'd0;
    localparam logic [2:0] CFG_SIZE_THRESHOLD  = 3'd1;
    localparam logic [2:0] CFG_ENCODING_BITS   = 3'd2;
    localparam logic [2:0] CFG_FAIL_THRESHOLD  = 3'd3;
    localparam logic [2:0] CFG_PROBE_INTERVAL  = 3'd4;
    localparam logic [2:0] CFG_COMP_EXTRA_LAT  = 3'd5;
    localparam logic [2:0] CFG_DECOMP_EXTRA_LAT = 3'd6;

    typedef struct packed {
        logic [12:0] size_bits;
        logic [7:0]  comp_latency;
        logic [7:0]  decomp_latency;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  winner_index;
        logic [12:0] best_size_bits;
        logic [8:0]  line_comp_latency;
        logic [8:0]  line_decomp_latency;
        logic [3:0]  considered_mask;
    } t_out_item;

endpackage

`default_nettype wire

### src/multi_compressor_selector_top.sv
// ----------------------------------------------------------------------------
// multi_compressor_selector_top
// Buffers one sub-compressor result per item and, on the last item of a
// line, selects the best result and updates per-compressor failure tracking.
// ----------------------------------------------------------------------------
// sequence: a non-last item is only buffered; a last item runs, in order, a probe
//   modulo pass when probing is on, a factor divide for each result that needs one,
//   a select step, a pick step per result and a finish step, the modulo and the
//   factor divides sharing one restoring divide unit
// throughput: one item at a time; input stalls while a line is evaluated
//   and while a finished result waits for the previous one to be taken
// reset: synchronous active low, clears tracking and counters and sets config to its defaults
`default_nettype none

module multi_compressor_selector_top #(
    parameter int COMP_COUNT = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  mcs_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  wire                 i_stall,
    output mcs_pkg::t_out_item  o_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [2:0]          i_cfg_index,
    input  wire  [15:0]         i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_MOD, S_EVAL, S_DIV, S_SEL, S_PICK, S_FIN
    } t_state;

    t_state r_state;

    logic [8:0]  r_block_bytes, r_size_thr;
    logic [1:0]  r_enc_bits;
    logic [15:0] r_fail_thr, r_probe;
    logic [7:0]  r_cext, r_dext;

    logic [12:0] r_buf_size [mcs_pkg::SLOTS];
    logic [7:0]  r_buf_clat [mcs_pkg::SLOTS];
    logic [7:0]  r_buf_dlat [mcs_pkg::SLOTS];
    logic [12:0] r_sized    [mcs_pkg::SLOTS];
    logic [9:0]  r_factor   [mcs_pkg::SLOTS];
    logic [15:0] r_fail_cnt [mcs_pkg::SLOTS];
    logic [3:0]  r_ok, r_unp, r_cons;

    logic [1:0]  r_arrival, r_last_i, r_i;
    logic [31:0] r_line;
    logic        r_periodic;

    logic [31:0] r_dvd;
    logic [16:0] r_rem;
    logic [15:0] r_dvs;
    logic [5:0]  r_step;

    logic        r_have;
    logic [1:0]  r_best;
    logic [9:0]  r_best_factor;
    logic [7:0]  r_best_dlat, r_max_clat;
    logic [12:0] r_best_size;

    logic        r_out_valid;
    mcs_pkg::t_out_item r_out;

    function automatic logic [9:0] ceil_pow2(input logic [8:0] q);
        logic [9:0] p;
        p = 10'd512;
        for (int k = 9; k >= 0; k--) begin
            if ((10'd1 << k) >= {1'b0, q}) p = 10'd1 << k;
        end
        return p;
    endfunction

    // shared restoring divide step
    logic [16:0] rem_sh, rem_nx;
    logic        q_bit;
    always_comb begin
        rem_sh = {r_rem[15:0], r_dvd[31]};
        q_bit  = rem_sh >= {1'b0, r_dvs};
        rem_nx = q_bit ? rem_sh - {1'b0, r_dvs} : rem_sh;
    end

    // per-result evaluation
    logic [13:0] s_sum;
    logic [12:0] sized;
    logic [13:0] bytes_sum;
    logic [10:0] bytes;
    logic        ok;
    always_comb begin
        s_sum     = {1'b0, r_buf_size[r_i]} + {12'd0, r_enc_bits};
        sized     = (s_sum > {1'b0, mcs_pkg::SIZE_MAX_BITS}) ?
                    mcs_pkg::SIZE_MAX_BITS : s_sum[12:0];
        bytes_sum = {1'b0, sized} + 14'd7;
        bytes     = bytes_sum[13:3];
        ok        = (bytes <= {2'b0, r_size_thr}) && (bytes < {2'b0, r_block_bytes});
    end

    // consideration of the line
    logic [3:0] nmask, cons_base;
    logic       all_unp;
    always_comb begin
        for (int k = 0; k < mcs_pkg::SLOTS; k++) begin
            nmask[k] = (2'(k) <= r_last_i);
        end
        all_unp   = ((r_unp | ~nmask) == 4'hf);
        cons_base = (~r_unp | {4{r_periodic | all_unp}}) & nmask;
    end

    // pick step
    logic [15:0] cnt_inc;
    logic        better;
    logic [8:0]  dlat_sum, clat_sum;
    always_comb begin
        cnt_inc  = (r_fail_cnt[r_i] == 16'hffff) ? 16'hffff : r_fail_cnt[r_i] + 16'd1;
        better   = !r_have || (r_factor[r_i] > r_best_factor) ||
                   ((r_factor[r_i] == r_best_factor) && (r_buf_dlat[r_i] < r_best_dlat));
        dlat_sum = {1'b0, r_best_dlat} + {1'b0, r_dext};
        clat_sum = {1'b0, r_max_clat} + {1'b0, r_cext};
    end

    logic [1:0] slot;
    assign slot = r_arrival;

    logic out_load;
    assign out_load = (r_state == S_FIN) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_block_bytes <= 9'd64;
            r_size_thr    <= 9'd64;
            r_enc_bits    <= 2'd2;
            r_fail_thr    <= 16'd0;
            r_probe       <= 16'd0;
            r_cext        <= 8'd1;
            r_dext        <= 8'd1;
            r_arrival     <= 2'd0;
            r_line        <= 32'd0;
            r_unp         <= 4'd0;
            r_out_valid   <= 1'b0;
            for (int k = 0; k < mcs_pkg::SLOTS; k++) r_fail_cnt[k] <= 16'd0;
        end else begin
            r_out_valid <= out_load || (r_out_valid && i_stall);
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    mcs_pkg::CFG_BLOCK_BYTES:      r_block_bytes <= i_cfg_data[8:0];
                    mcs_pkg::CFG_SIZE_THRESHOLD:   r_size_thr    <= i_cfg_data[8:0];
                    mcs_pkg::CFG_ENCODING_BITS:    r_enc_bits    <= i_cfg_data[1:0];
                    mcs_pkg::CFG_FAIL_THRESHOLD:   r_fail_thr    <= i_cfg_data;
                    mcs_pkg::CFG_PROBE_INTERVAL:   r_probe       <= i_cfg_data;
                    mcs_pkg::CFG_COMP_EXTRA_LAT:   r_cext        <= i_cfg_data[7:0];
                    mcs_pkg::CFG_DECOMP_EXTRA_LAT: r_dext        <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_buf_size[slot] <= i_data.size_bits;
                        r_buf_clat[slot] <= i_data.comp_latency;
                        r_buf_dlat[slot] <= i_data.decomp_latency;
                        if (!i_data.last) begin
                            if (32'(slot) + 32'd1 < 32'(COMP_COUNT))
                                r_arrival <= slot + 2'd1;
                        end else begin
                            r_arrival  <= 2'd0;
                            r_last_i   <= slot;
                            r_i        <= 2'd0;
                            r_line     <= r_line + 32'd1;
                            r_periodic <= 1'b0;
                            r_dvd      <= r_line + 32'd1;
                            r_dvs      <= r_probe;
                            r_rem      <= 17'd0;
                            r_step     <= mcs_pkg::MOD_STEPS;
                            r_state    <= (r_probe != 16'd0) ? S_MOD : S_EVAL;
                        end
                    end
                end
                S_MOD, S_DIV: begin
                    r_rem  <= rem_nx;
                    r_dvd  <= {r_dvd[30:0], q_bit};
                    r_step <= r_step - 6'd1;
                    if (r_step == 6'd1) begin
                        if (r_state == S_MOD) begin
                            r_periodic <= (rem_nx == 17'd0);
                            r_state    <= S_EVAL;
                        end else begin
                            r_factor[r_i] <= ceil_pow2({r_dvd[7:0], q_bit});
                            r_i           <= r_i + 2'd1;
                            r_state       <= (r_i == r_last_i) ? S_SEL : S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    r_sized[r_i] <= sized;
                    r_ok[r_i]    <= ok;
                    if (bytes > {2'b0, r_block_bytes} || bytes == 11'd0) begin
                        r_factor[r_i] <= (bytes == 11'd0) ? {1'b0, r_block_bytes} : 10'd1;
                        r_i           <= r_i + 2'd1;
                        r_state       <= (r_i == r_last_i) ? S_SEL : S_EVAL;
                    end else begin
                        r_dvd   <= {r_block_bytes, 23'd0};
                        r_dvs   <= {5'd0, bytes};
                        r_rem   <= 17'd0;
                        r_step  <= mcs_pkg::FACTOR_STEPS;
                        r_state <= S_DIV;
                    end
                end
                S_SEL: begin
                    r_cons     <= ((cons_base & r_ok) != 4'd0) ? cons_base : nmask;
                    r_have     <= 1'b0;
                    r_max_clat <= 8'd0;
                    r_i        <= 2'd0;
                    r_state    <= S_PICK;
                end
                S_PICK: begin
                    if (r_cons[r_i]) begin
                        if (r_buf_clat[r_i] > r_max_clat) r_max_clat <= r_buf_clat[r_i];
                        if (better) begin
                            r_have        <= 1'b1;
                            r_best        <= r_i;
                            r_best_factor <= r_factor[r_i];
                            r_best_dlat   <= r_buf_dlat[r_i];
                            r_best_size   <= r_sized[r_i];
                        end
                        if (r_ok[r_i]) begin
                            r_fail_cnt[r_i] <= 16'd0;
                            r_unp[r_i]      <= 1'b0;
                        end else begin
                            r_fail_cnt[r_i] <= cnt_inc;
                            if (r_fail_thr != 16'd0 && cnt_inc >= r_fail_thr)
                                r_unp[r_i] <= 1'b1;
                        end
                    end
                    r_i     <= r_i + 2'd1;
                    r_state <= (r_i == r_last_i) ? S_FIN : S_PICK;
                end
                S_FIN: begin
                    if (out_load) begin
                        r_out.winner_index        <= r_best;
                        r_out.best_size_bits      <= r_best_size;
                        r_out.line_comp_latency   <= clat_sum;
                        r_out.line_decomp_latency <=
                            (r_best_size >= {1'b0, r_block_bytes, 3'd0}) ? 9'd0 : dlat_sum;
                        r_out.considered_mask     <= r_cons;
                        r_state                   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_data.last) |=> o_stall)
        else $error("last item did not start evaluation");
    a_arrival_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_arrival) < 32'(COMP_COUNT)) else $error("arrival index out of range");
    a_mask_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.considered_mask[o_data.winner_index])
        else $error("winner not considered");

endmodule

`default_nettype wire

### verif/mcs_line_checker.sv
// ----------------------------------------------------------------------------
// mcs_line_checker
// Watches the item and result channels of the selector, keeps its own copy of
// the buffered results, failure tracking and registers, predicts the result of
// every line and compares each result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcs_line_checker #(
    parameter int COMP_COUNT = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire                 i_stall_in,
    input  mcs_pkg::t_in_item   i_data,
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    input  mcs_pkg::t_out_item  i_out_data,
    input  wire                 i_cfg_valid,
    input  wire                 i_cfg_ready,
    input  wire  [2:0]          i_cfg_index,
    input  wire  [15:0]         i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_lines_checked
);

    logic [8:0]  blk_bytes, thr_bytes;
    logic [1:0]  enc_bits;
    logic [15:0] fail_thr, probe_int;
    logic [7:0]  cx_lat, dx_lat;
    logic [12:0] sz_buf [mcs_pkg::SLOTS];
    logic [7:0]  cl_buf [mcs_pkg::SLOTS];
    logic [7:0]  dl_buf [mcs_pkg::SLOTS];
    logic [1:0]  slot_ptr;
    logic [15:0] fails [mcs_pkg::SLOTS];
    logic        unprom [mcs_pkg::SLOTS];
    logic [31:0] lines;
    mcs_pkg::t_out_item exp_fifo [64];
    logic [5:0]  wr_ptr, rd_ptr;
    int          exp_count;

    function automatic logic [31:0] pow2_up(input logic [31:0] x);
        logic [31:0] p;
        p = 1;
        while (p < x && p < 32'h8000_0000) p = p << 1;
        return p;
    endfunction

    task automatic close_line(input int n);
        logic [12:0] sized [mcs_pkg::SLOTS];
        logic [31:0] fac [mcs_pkg::SLOTS];
        logic        ok [mcs_pkg::SLOTS];
        logic        cons [mcs_pkg::SLOTS];
        logic        periodic, all_unp, any_ok, have;
        int          best;
        logic [31:0] s, bytes, max_cl, dl;
        logic [3:0]  mask;
        mcs_pkg::t_out_item r;
        all_unp = 1; any_ok = 0; have = 0; best = 0; max_cl = 0; mask = 0;
        lines = lines + 1;
        periodic = probe_int != 0 && (lines % probe_int) == 0;
        for (int i = 0; i < n; i++) begin
            s = sz_buf[i] + enc_bits;
            if (s > mcs_pkg::SIZE_MAX_BITS) s = mcs_pkg::SIZE_MAX_BITS;
            sized[i] = s[12:0];
            bytes = (s + 7) / 8;
            ok[i] = bytes <= thr_bytes && bytes < blk_bytes;
            if (bytes > blk_bytes) fac[i] = 1;
            else if (bytes == 0) fac[i] = blk_bytes;
            else fac[i] = pow2_up(blk_bytes / bytes);
            if (!unprom[i]) all_unp = 0;
        end
        for (int i = 0; i < n; i++) begin
            cons[i] = !unprom[i] || periodic || all_unp;
            if (cons[i] && ok[i]) any_ok = 1;
        end
        if (!any_ok) for (int i = 0; i < n; i++) cons[i] = 1;
        for (int i = 0; i < n; i++) begin
            if (cons[i]) begin
                mask[i] = 1'b1;
                if (cl_buf[i] > max_cl) max_cl = cl_buf[i];
                if (!have || fac[i] > fac[best] ||
                    (fac[i] == fac[best] && dl_buf[i] < dl_buf[best])) begin
                    best = i;
                    have = 1;
                end
                if (ok[i]) begin
                    fails[i] = 0;
                    unprom[i] = 0;
                end else begin
                    if (fails[i] != 16'hFFFF) fails[i] = fails[i] + 1;
                    if (fail_thr != 0 && fails[i] >= fail_thr) unprom[i] = 1;
                end
            end
        end
        if (32'(sized[best]) >= 32'(blk_bytes) * 8) dl = 0;
        else dl = dl_buf[best] + dx_lat;
        r.winner_index = best[1:0];
        r.best_size_bits = sized[best];
        r.line_comp_latency = 9'(max_cl + cx_lat);
        r.line_decomp_latency = dl[8:0];
        r.considered_mask = mask;
        exp_fifo[wr_ptr] = r;
        wr_ptr = wr_ptr + 6'd1;
        exp_count = exp_count + 1;
    endtask

    always @(posedge i_clk) begin
        mcs_pkg::t_out_item e;
        if (!i_rst_n) begin
            blk_bytes <= 64; thr_bytes <= 64; enc_bits <= 2;
            fail_thr <= 0; probe_int <= 0; cx_lat <= 1; dx_lat <= 1;
            slot_ptr = 0; lines = 0;
            for (int i = 0; i < mcs_pkg::SLOTS; i++) begin
                fails[i] = 0;
                unprom[i] = 0;
            end
            wr_ptr = 0; rd_ptr = 0; exp_count = 0;
            o_fail_count <= 0;
            o_lines_checked <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    mcs_pkg::CFG_BLOCK_BYTES:      blk_bytes <= i_cfg_data[8:0];
                    mcs_pkg::CFG_SIZE_THRESHOLD:   thr_bytes <= i_cfg_data[8:0];
                    mcs_pkg::CFG_ENCODING_BITS:    enc_bits <= i_cfg_data[1:0];
                    mcs_pkg::CFG_FAIL_THRESHOLD:   fail_thr <= i_cfg_data;
                    mcs_pkg::CFG_PROBE_INTERVAL:   probe_int <= i_cfg_data;
                    mcs_pkg::CFG_COMP_EXTRA_LAT:   cx_lat <= i_cfg_data[7:0];
                    mcs_pkg::CFG_DECOMP_EXTRA_LAT: dx_lat <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (exp_count == 0) begin
                    $error("unexpected result %h", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = exp_fifo[rd_ptr];
                    rd_ptr = rd_ptr + 6'd1;
                    exp_count = exp_count - 1;
                    o_lines_checked <= o_lines_checked + 1;
                    if (e != i_out_data) begin
                        o_fail_count <= o_fail_count + 1;
                        if (e.winner_index != i_out_data.winner_index)
                            $error("winner_index exp %0d got %0d",
                                   e.winner_index, i_out_data.winner_index);
                        if (e.best_size_bits != i_out_data.best_size_bits)
                            $error("best_size_bits exp %0d got %0d",
                                   e.best_size_bits, i_out_data.best_size_bits);
                        if (e.line_comp_latency != i_out_data.line_comp_latency)
                            $error("line_comp_latency exp %0d got %0d",
                                   e.line_comp_latency, i_out_data.line_comp_latency);
                        if (e.line_decomp_latency != i_out_data.line_decomp_latency)
                            $error("line_decomp_latency exp %0d got %0d",
                                   e.line_decomp_latency,
                                   i_out_data.line_decomp_latency);
                        if (e.considered_mask != i_out_data.considered_mask)
                            $error("considered_mask exp %b got %b",
                                   e.considered_mask, i_out_data.considered_mask);
                    end
                end
            end
            if (i_valid && !i_stall_in) begin
                sz_buf[slot_ptr] = i_data.size_bits;
                cl_buf[slot_ptr] = i_data.comp_latency;
                dl_buf[slot_ptr] = i_data.decomp_latency;
                if (i_data.last) begin
                    close_line(int'(slot_ptr) + 1);
                    slot_ptr = 0;
                end else if (int'(slot_ptr) + 1 < COMP_COUNT) begin
                    slot_ptr = slot_ptr + 1;
                end
            end
        end
        o_pending <= exp_count;
    end
endmodule

`default_nettype wire

### verif/multi_compressor_selector_top_test.sv
// ----------------------------------------------------------------------------
// multi_compressor_selector_top_test
// Drives lines of sub-compressor results into the selector under several
// register settings, with bursty input and random output stalls, and reports
// the verdict from the line checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_compressor_selector_top_test;

    localparam int NCOMP = 4;

    logic       clk = 0;
    logic       rst_n = 0;
    logic       in_valid = 0;
    logic       in_stall;
    mcs_pkg::t_in_item  in_item = '0;
    logic       out_valid;
    logic       out_stall = 0;
    mcs_pkg::t_out_item out_item;
    logic       cfg_valid = 0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int         fail_count, pending, lines_checked;
    int         items_sent = 0;
    bit         long_hold = 0;
    bit         hold_done = 0;

    always begin
        #4 clk = 1;
        #4 clk = 0;
    end

    multi_compressor_selector_top #(.COMP_COUNT(NCOMP)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_item),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    mcs_line_checker #(.COMP_COUNT(NCOMP)) u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_stall_in(in_stall), .i_data(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_item),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_lines_checked(lines_checked)
    );

    // receiver stall pattern, with one long hold-off
    always @(negedge clk) begin
        if (long_hold) out_stall <= 1;
        else case ((items_sent / 200) % 3)
            0: out_stall <= 0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic send_item(input logic [12:0] sz, input logic [7:0] cl,
                             input logic [7:0] dl, input logic lst);
        in_item = '{size_bits: sz, comp_latency: cl, decomp_latency: dl, last: lst};
        in_valid = 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic send_random_line(input int mode);
        int n;
        logic [12:0] sz;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : NCOMP;
        for (int k = 0; k < n; k++) begin
            case (mode)
                0: sz = 13'($urandom);
                1: sz = 13'($urandom_range(0, 700));
                default: sz = ($urandom_range(0, 1)) ? 13'($urandom_range(0, 64))
                                                     : 13'($urandom_range(400, 8191));
            endcase
            send_item(sz, 8'($urandom), 8'($urandom), k == n - 1);
        end
    endtask

    task automatic drain;
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic set_regs(input logic [15:0] bb, input logic [15:0] th,
                            input logic [15:0] eb, input logic [15:0] ft,
                            input logic [15:0] pi, input logic [15:0] cx,
                            input logic [15:0] dx);
        write_reg(mcs_pkg::CFG_BLOCK_BYTES, bb);
        write_reg(mcs_pkg::CFG_SIZE_THRESHOLD, th);
        write_reg(mcs_pkg::CFG_ENCODING_BITS, eb);
        write_reg(mcs_pkg::CFG_FAIL_THRESHOLD, ft);
        write_reg(mcs_pkg::CFG_PROBE_INTERVAL, pi);
        write_reg(mcs_pkg::CFG_COMP_EXTRA_LAT, cx);
        write_reg(mcs_pkg::CFG_DECOMP_EXTRA_LAT, dx);
    endtask

    initial begin
        int gap;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: extremes, zero sizes, ties, short and long lines
        send_item(13'd0, 8'd0, 8'd0, 0);
        send_item(13'd8191, 8'd255, 8'd255, 0);
        send_item(13'd8190, 8'd255, 8'd0, 0);
        send_item(13'd100, 8'd7, 8'd9, 1);
        send_item(13'd64, 8'd3, 8'd5, 0);
        send_item(13'd64, 8'd4, 8'd2, 0);
        send_item(13'd64, 8'd5, 8'd2, 0);
        send_item(13'd64, 8'd6, 8'd8, 1);
        send_item(13'd300, 8'd1, 8'd1, 1);
        send_item(13'd511, 8'd2, 8'd3, 0);
        send_item(13'd5000, 8'd9, 8'd4, 1);
        for (int k = 0; k < 6; k++) send_item(13'(k * 150), 8'(k), 8'(200 - k), k == 5);
        drain();

        set_regs(0, 0, 0, 1, 1, 0, 0);
        send_item(13'd0, 8'd1, 8'd1, 0);
        send_item(13'd8, 8'd2, 8'd2, 1);
        drain();
        set_regs(256, 256, 3, 2, 3, 255, 255);
        send_item(13'd8191, 8'd255, 8'd255, 0);
        send_item(13'd8191, 8'd0, 8'd0, 0);
        send_item(13'd0, 8'd0, 8'd0, 0);
        send_item(13'd2047, 8'd128, 8'd128, 1);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_regs(64, 64, 2, 0, 0, 1, 1);
                1: set_regs(16'($urandom_range(8, 256)), 16'($urandom_range(0, 256)),
                            16'($urandom_range(0, 3)), 16'($urandom_range(1, 4)),
                            16'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
                2: set_regs(8, 0, 1, 1, 65535, 0, 255);
                3: set_regs(256, 256, 0, 65535, 2, 255, 0);
                4: set_regs(16'h01FF, 16'h01FF, 16'h0003, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF);
                default: set_regs(32, 20, 2, 3, 5, 10, 20);
            endcase
            while (items_sent < 300 + ph * 250) begin
                if (ph == 2 && !hold_done && items_sent > 650) begin
                    hold_done = 1;
                    fork
                        begin
                            long_hold = 1;
                            repeat (400) @(posedge clk);
                            long_hold = 0;
                        end
                    join_none
                end
                repeat ($urandom_range(1, 4)) send_random_line(ph % 3);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
                repeat (gap) @(negedge clk);
                if (ph == 4 && $urandom_range(0, 20) == 0) begin
                    while (pending != 0) @(posedge clk);
                    @(negedge clk);
                end
            end
            drain();
        end

        $display("ran %0d items, %0d lines checked across several register settings",
                 items_sent, lines_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

`default_nettype wire

### multi_compressor_selector_top.f
src/mcs_pkg.sv
src/multi_compressor_selector_top.sv
verif/mcs_line_checker.sv
verif/multi_compressor_selector_top_test.sv
